// ----- rtl/fcpu_pkg.sv -----
// shared types and constants of the fly camera pose update core
package fcpu_pkg;

  typedef enum logic [1:0] {
    OP_LOOK    = 2'd0,
    OP_MOVE    = 2'd1,
    OP_ZOOM    = 2'd2,
    OP_RESTART = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_MOVE_SPEED = 2'd0,
    REG_START_X    = 2'd1,
    REG_START_Y    = 2'd2,
    REG_START_Z    = 2'd3
  } reg_e;

  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned CordicSteps = 16;
  localparam logic signed [17:0] YawFull  = 18'sd92160;
  localparam logic signed [17:0] YawHalf  = 18'sd46080;
  localparam logic signed [17:0] YawQuart = 18'sd23040;
  localparam logic signed [17:0] PitchMax = 18'sd22784;
  localparam logic signed [17:0] ZoomMin  = 18'sd256;
  localparam logic signed [17:0] ZoomMax  = 18'sd11520;
  localparam logic signed [15:0] Unit     = 16'sd16384;
  localparam logic signed [31:0] CordicGain = 32'sd10188014;

  // one queued item after decode
  typedef struct packed {
    op_e               op;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic        [2:0]  move_dir;
    logic        [15:0] time_step;
  } item_t;

  function automatic logic signed [31:0] atan_lut(input logic [3:0] i);
    logic signed [31:0] r;
    begin
      case (i)
        4'd0:  r = 32'sd2949120;
        4'd1:  r = 32'sd1740967;
        4'd2:  r = 32'sd919879;
        4'd3:  r = 32'sd466945;
        4'd4:  r = 32'sd234379;
        4'd5:  r = 32'sd117304;
        4'd6:  r = 32'sd58666;
        4'd7:  r = 32'sd29335;
        4'd8:  r = 32'sd14668;
        4'd9:  r = 32'sd7334;
        4'd10: r = 32'sd3667;
        4'd11: r = 32'sd1833;
        4'd12: r = 32'sd917;
        4'd13: r = 32'sd458;
        4'd14: r = 32'sd229;
        default: r = 32'sd115;
      endcase
      return r;
    end
  endfunction

  // round half away from zero by 14 bits, clamp to unit
  function automatic logic signed [15:0] rnd14_unit(input logic signed [31:0] v);
    logic signed [31:0] a;
    logic signed [31:0] r;
    begin
      a = v[31] ? -v : v;
      a = (a + 32'sd8192) >>> 14;
      r = v[31] ? -a : a;
      if (r > 32'sd16384) r = 32'sd16384;
      if (r < -32'sd16384) r = -32'sd16384;
      return r[15:0];
    end
  endfunction

endpackage

// ----- rtl/fcpu_front.sv -----
// input stage: takes items and queues them for the execution unit
module fcpu_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  logic [1:0]     op_i,
  input  logic [15:0]    delta_x_i,
  input  logic [15:0]    delta_y_i,
  input  logic [2:0]     move_dir_i,
  input  logic [15:0]    time_step_i,
  output logic           q_valid_o,
  input  logic           q_take_i,
  output fcpu_pkg::item_t q_item_o
);
  import fcpu_pkg::*;

  item_t       mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        do_push, do_take;

  assign full      = (cnt_q == 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign do_push   = push && !full;
  assign do_take   = q_take_i && q_valid_o;
  assign q_item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= '{op: op_e'(op_i), delta_x: delta_x_i, delta_y: delta_y_i,
                       move_dir: move_dir_i, time_step: time_step_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_take) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_take};
    end
  end
endmodule

// ----- rtl/fcpu_back.sv -----
// execution unit: pose state, cordic, basis rebuild, moves and result register
module fcpu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              q_valid_i,
  output logic              q_take_o,
  input  fcpu_pkg::item_t   q_item_i,
  output logic              empty,
  input  logic              pop,
  output logic [31:0]       pos_out_x_o,
  output logic [31:0]       pos_out_y_o,
  output logic [31:0]       pos_out_z_o,
  output logic [15:0]       front_out_x_o,
  output logic [15:0]       front_out_y_o,
  output logic [15:0]       front_out_z_o,
  output logic [15:0]       up_out_x_o,
  output logic [15:0]       up_out_y_o,
  output logic [15:0]       up_out_z_o,
  output logic [16:0]       zoom_out_o,
  output logic [16:0]       yaw_out_o,
  output logic [15:0]       pitch_out_o
);
  import fcpu_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CORD  = 7'b0000010,
    S_CEND  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_MOVE  = 7'b0010000,
    S_AXIS  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q;
  item_t  it_q;

  logic [15:0]        speed_q;
  logic signed [31:0] start_x_q, start_y_q, start_z_q;
  logic signed [31:0] pos_q [3];
  logic [16:0]        yaw_q;
  logic signed [15:0] pitch_q;
  logic signed [17:0] zoom_q;
  logic signed [15:0] bas_q [9];

  // cordic
  logic               which_q;   // 0 yaw, 1 pitch
  logic [3:0]         step_q;
  logic signed [31:0] cx_q, cy_q, cz_q;
  logic               neg_q;
  logic signed [15:0] sy_q, cy2_q, sp_q, cp_q;
  logic [3:0]         mcnt_q;
  logic [1:0]         axis_q;
  logic [31:0]        vel_q;
  logic signed [47:0] prod_q;

  logic               res_valid_q;

  assign empty    = !res_valid_q;
  assign q_take_o = (state_q == S_IDLE) && q_valid_i;

  // angle fold for cordic start
  logic signed [17:0] ang, fa;
  logic               fneg;
  always_comb begin
    ang = which_q ? 18'(pitch_q) : $signed({1'b0, yaw_q});
    if (ang > YawHalf) ang = ang - YawFull;
    if (ang < -YawHalf) ang = ang + YawFull;
    fneg = 1'b0;
    fa   = ang;
    if (ang > YawQuart) begin
      fa = ang - YawHalf; fneg = 1'b1;
    end else if (ang < -YawQuart) begin
      fa = ang + YawHalf; fneg = 1'b1;
    end
  end

  // cordic output rounding by 10 bits
  function automatic logic signed [15:0] rnd10(input logic signed [31:0] v, input logic n);
    logic signed [31:0] w, a;
    begin
      w = n ? -v : v;
      a = w[31] ? -w : w;
      a = (a + 32'sd512) >>> 10;
      a = w[31] ? -a : a;
      if (a > 32'sd16384) a = 32'sd16384;
      if (a < -32'sd16384) a = -32'sd16384;
      return a[15:0];
    end
  endfunction

  // look update
  logic signed [18:0] ny;
  logic signed [17:0] np;
  always_comb begin
    ny = $signed({2'b0, yaw_q}) + 19'(it_q.delta_x);
    if (ny < 0) ny = ny + 19'(YawFull);
    else if (ny >= 19'(YawFull)) ny = ny - 19'(YawFull);
    np = 18'(pitch_q) + 18'(it_q.delta_y);
    if (np > PitchMax) np = PitchMax;
    if (np < -PitchMax) np = -PitchMax;
  end

  // shared multiplier for basis products
  logic signed [15:0] ma, mb;
  always_comb begin
    case (mcnt_q)
      4'd0: begin ma = cy2_q; mb = cp_q; end
      4'd1: begin ma = sy_q;  mb = cp_q; end
      4'd2: begin ma = cy2_q; mb = sp_q; end
      default: begin ma = sy_q; mb = sp_q; end
    endcase
  end
  logic signed [31:0] mprod;
  assign mprod = ma * mb;

  // move: component select and rounding
  logic [1:0]         base;
  logic signed [15:0] comp;
  logic signed [47:0] ad, rd;
  logic signed [32:0] np33;
  logic signed [31:0] sat;
  always_comb begin
    base = it_q.move_dir[2:1];
    comp = bas_q[4'(base) * 4'd3 + 4'(axis_q)];
    ad   = prod_q[47] ? -prod_q : prod_q;
    ad   = (ad + 48'sd2097152) >>> 22;
    rd   = prod_q[47] ? -ad : ad;
    if (it_q.move_dir[0]) np33 = 33'(pos_q[axis_q]) - 33'(rd);
    else np33 = 33'(pos_q[axis_q]) + 33'(rd);
    if (np33 > 33'sd2147483647) sat = 32'h7fffffff;
    else if (np33 < -33'sd2147483648) sat = 32'h80000000;
    else sat = np33[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && q_valid_i) it_q <= q_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      speed_q <= 16'd640;
      start_x_q <= '0; start_y_q <= '0; start_z_q <= '0;
      for (int i = 0; i < 3; i++) pos_q[i] <= '0;
      yaw_q <= '0; pitch_q <= '0; zoom_q <= ZoomMax;
      bas_q[0] <= Unit; bas_q[1] <= '0; bas_q[2] <= '0;
      bas_q[3] <= '0;   bas_q[4] <= '0; bas_q[5] <= Unit;
      bas_q[6] <= '0;   bas_q[7] <= Unit; bas_q[8] <= '0;
      which_q <= 1'b0; step_q <= '0; cx_q <= '0; cy_q <= '0; cz_q <= '0;
      neg_q <= 1'b0; sy_q <= '0; cy2_q <= '0; sp_q <= '0; cp_q <= '0;
      mcnt_q <= '0; axis_q <= '0; vel_q <= '0; prod_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_MOVE_SPEED: speed_q   <= cfg_data_i[15:0];
          REG_START_X:    start_x_q <= cfg_data_i;
          REG_START_Y:    start_y_q <= cfg_data_i;
          REG_START_Z:    start_z_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (pop && res_valid_q && state_q != S_OUT) res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (q_valid_i) begin
          unique case (q_item_i.op)
            OP_LOOK: begin
              which_q <= 1'b0;
              state_q <= S_CEND;
            end
            OP_MOVE: begin
              vel_q   <= $signed({16'b0, q_item_i.time_step}) * $signed({16'b0, speed_q});
              axis_q  <= '0;
              state_q <= S_MOVE;
            end
            OP_ZOOM: begin
              if (zoom_q >= ZoomMin && zoom_q <= ZoomMax)
                zoom_q <= zoom_q - 18'(q_item_i.delta_y);
              else if (zoom_q < ZoomMin) zoom_q <= ZoomMin;
              else zoom_q <= ZoomMax;
              state_q <= S_OUT;
            end
            default: begin
              pos_q[0] <= start_x_q; pos_q[1] <= start_y_q; pos_q[2] <= start_z_q;
              yaw_q <= '0; pitch_q <= '0; zoom_q <= ZoomMax;
              bas_q[0] <= Unit; bas_q[1] <= '0; bas_q[2] <= '0;
              bas_q[3] <= '0;   bas_q[4] <= '0; bas_q[5] <= Unit;
              bas_q[6] <= '0;   bas_q[7] <= Unit; bas_q[8] <= '0;
              state_q <= S_OUT;
            end
          endcase
        end
        S_CEND: begin
          // first pass applies the look update, later passes start cordic
          if (!which_q && mcnt_q == 4'd0 && step_q == 4'd0 && !neg_q) begin
            yaw_q   <= ny[16:0];
            pitch_q <= np[15:0];
            neg_q   <= 1'b1;
          end else begin
            cx_q <= CordicGain; cy_q <= '0;
            cz_q <= 32'(fa) <<< 8;
            neg_q <= fneg;
            step_q <= '0;
            state_q <= S_CORD;
          end
        end
        S_CORD: begin
          if (!cz_q[31]) begin
            cx_q <= cx_q - (cy_q >>> step_q);
            cy_q <= cy_q + (cx_q >>> step_q);
            cz_q <= cz_q - atan_lut(step_q);
          end else begin
            cx_q <= cx_q + (cy_q >>> step_q);
            cy_q <= cy_q - (cx_q >>> step_q);
            cz_q <= cz_q + atan_lut(step_q);
          end
          step_q <= step_q + 4'd1;
          if (step_q == 4'(CordicSteps - 1)) begin
            state_q <= S_MUL;
            mcnt_q  <= 4'd8;
          end
        end
        S_MUL: begin
          if (mcnt_q == 4'd8) begin
            if (!which_q) begin
              sy_q <= rnd10(cy_q, neg_q); cy2_q <= rnd10(cx_q, neg_q);
              which_q <= 1'b1;
              state_q <= S_CEND;
              mcnt_q  <= 4'd9;
            end else begin
              sp_q <= rnd10(cy_q, neg_q); cp_q <= rnd10(cx_q, neg_q);
              mcnt_q <= 4'd0;
            end
          end else begin
            unique case (mcnt_q)
              4'd0: bas_q[0] <= rnd14_unit(mprod);
              4'd1: bas_q[2] <= rnd14_unit(mprod);
              4'd2: bas_q[6] <= rnd14_unit(-mprod);
              default: bas_q[8] <= rnd14_unit(-mprod);
            endcase
            if (mcnt_q == 4'd3) begin
              bas_q[1] <= sp_q; bas_q[3] <= -sy_q; bas_q[4] <= '0;
              bas_q[5] <= cy2_q; bas_q[7] <= cp_q;
              mcnt_q <= '0; neg_q <= 1'b0; which_q <= 1'b0;
              state_q <= S_OUT;
            end else mcnt_q <= mcnt_q + 4'd1;
          end
        end
        S_MOVE: begin
          if (it_q.move_dir > 3'd5) state_q <= S_OUT;
          else begin
            prod_q  <= $signed({16'b0, vel_q}) * 48'(comp);
            state_q <= S_AXIS;
          end
        end
        S_AXIS: begin
          pos_q[axis_q] <= sat;
          if (axis_q == 2'd2) state_q <= S_OUT;
          else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= S_MOVE;
          end
        end
        S_OUT: if (!res_valid_q || pop) begin
          res_valid_q <= 1'b1;
          pos_out_x_o <= pos_q[0]; pos_out_y_o <= pos_q[1]; pos_out_z_o <= pos_q[2];
          front_out_x_o <= bas_q[0]; front_out_y_o <= bas_q[1]; front_out_z_o <= bas_q[2];
          up_out_x_o <= bas_q[6]; up_out_y_o <= bas_q[7]; up_out_z_o <= bas_q[8];
          zoom_out_o <= zoom_q[16:0]; yaw_out_o <= yaw_q; pitch_out_o <= pitch_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/fly_camera_pose_update_core.sv -----
// top level of the fly camera pose update core
// channel  | signals                 | transfer when
// input    | push, full, op..time    | push && !full
// result   | empty, pop, pos..pitch  | pop && !empty
// config   | cfg_we_i, idx, data     | cfg_we_i
// look items run two 16-step cordic runs (yaw, then pitch) and four shared multiplies
// move items form one product per axis, updating x, y and z in turn; an unused direction forms none
// zoom and restart go straight to the result register; a queued item reaches the unit when it is idle
// reset clears the pose to its home values and empties the two-entry queue that holds items while the unit is busy
// the result register holds one result until popped and stalls the unit
module fly_camera_pose_update_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op_i,
  input  logic [15:0] delta_x_i,
  input  logic [15:0] delta_y_i,
  input  logic [2:0]  move_dir_i,
  input  logic [15:0] time_step_i,
  output logic        empty,
  input  logic        pop,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output logic [31:0] pos_out_x_o,
  output logic [31:0] pos_out_y_o,
  output logic [31:0] pos_out_z_o,
  output logic [15:0] front_out_x_o,
  output logic [15:0] front_out_y_o,
  output logic [15:0] front_out_z_o,
  output logic [15:0] up_out_x_o,
  output logic [15:0] up_out_y_o,
  output logic [15:0] up_out_z_o,
  output logic [16:0] zoom_out_o,
  output logic [16:0] yaw_out_o,
  output logic [15:0] pitch_out_o
);
  import fcpu_pkg::*;

  logic  q_valid, q_take;
  item_t q_item;

  fcpu_front u_front (
    .clk_i, .rst_ni, .push, .full, .op_i, .delta_x_i, .delta_y_i,
    .move_dir_i, .time_step_i,
    .q_valid_o(q_valid), .q_take_i(q_take), .q_item_o(q_item)
  );

  fcpu_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_take_o(q_take), .q_item_i(q_item),
    .empty, .pop,
    .pos_out_x_o, .pos_out_y_o, .pos_out_z_o,
    .front_out_x_o, .front_out_y_o, .front_out_z_o,
    .up_out_x_o, .up_out_y_o, .up_out_z_o,
    .zoom_out_o, .yaw_out_o, .pitch_out_o
  );

`ifndef SYNTH
  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> yaw_out_o < 17'd92160) else $error("yaw out of range");
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ($signed(pitch_out_o) <= 16'sd22784 && $signed(pitch_out_o) >= -16'sd22784))
    else $error("pitch out of range");
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_take |-> q_valid) else $error("take from empty queue");
`endif
endmodule
